// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define GPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked at every clock edge outside reset.
`define GPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// File: rtl/core/gpr_pkg.sv
// Shared types and constants of the pyramid reduce block.
`timescale 1ns / 1ps
package gpr_pkg;

  localparam int unsigned MAX_WIDTH     = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned RESET_WIDTH   = 2048;
  localparam int unsigned RESET_HEIGHT  = 2048;
  localparam int unsigned SAMPLE_BITS   = 20;
  localparam int unsigned BLUR_BITS     = SAMPLE_BITS + 2;
  localparam int unsigned PAIR_BITS     = BLUR_BITS + 1;
  localparam int unsigned HALF_BITS     = PAIR_BITS + 1;
  localparam int unsigned SUM_BITS      = SAMPLE_BITS + 6;
  localparam int unsigned PAIR_DEPTH    = MAX_WIDTH / 2;
  localparam int unsigned PAIR_AW       = $clog2(PAIR_DEPTH);
  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int unsigned WCFG_BITS     = 12;
  localparam int unsigned HCFG_BITS     = 13;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned OUT_COL_BITS  = 10;
  localparam int unsigned OUT_ROW_BITS  = 11;
  localparam int unsigned NUM_BANKS     = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef logic signed [PAIR_BITS-1:0] pair_t;
  typedef logic [PAIR_AW-1:0]          pair_addr_t;
  typedef logic [1:0]                  bank_t;

  typedef struct packed {
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample;
  } gpr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] reduced_sample;
    logic [OUT_COL_BITS-1:0]       out_col;
    logic [OUT_ROW_BITS-1:0]       out_row;
    logic                          last_of_frame;
  } gpr_out_t;

  typedef struct packed {
    logic                    emit;
    logic                    drain;
    bank_t                   b1;
    bank_t                   b2;
    bank_t                   b3;
    logic                    dup;
    pair_t                   cur;
    logic [OUT_COL_BITS-1:0] col;
    logic [OUT_ROW_BITS-1:0] row;
    logic                    last;
  } gpr_req_t;

  typedef struct packed {
    logic       we;
    bank_t      bank;
    pair_addr_t addr;
    pair_t      data;
  } gpr_wr_t;

endpackage

// File: rtl/core/gpr_line_bank.sv
// One line store bank: column-pair sums of row-blurred samples.
`timescale 1ns / 1ps
module gpr_line_bank (
  input  logic               clk_i,
  input  logic               we_i,
  input  gpr_pkg::pair_addr_t waddr_i,
  input  gpr_pkg::pair_t     wdata_i,
  input  logic               re_i,
  input  gpr_pkg::pair_addr_t raddr_i,
  output gpr_pkg::pair_t     rdata_o
);
  import gpr_pkg::*;

  pair_t mem [PAIR_DEPTH];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gpr_front.sv
// Front end: configuration, raster counters, row blur and line store access.
`timescale 1ns / 1ps
module gpr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [gpr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              accept_i,
  input  gpr_pkg::gpr_in_t                  item_i,
  output gpr_pkg::gpr_req_t                 req_o,
  output gpr_pkg::gpr_wr_t                  wr_o,
  output gpr_pkg::pair_addr_t               rd_addr_o
);
  import gpr_pkg::*;

  localparam logic [WCFG_BITS-1:0] W_MIN = WCFG_BITS'(2);
  localparam logic [WCFG_BITS-1:0] W_MAX = WCFG_BITS'(MAX_WIDTH);
  localparam logic [HCFG_BITS-1:0] H_MIN = HCFG_BITS'(2);
  localparam logic [HCFG_BITS-1:0] H_MAX = HCFG_BITS'(MAX_HEIGHT);

  function automatic bank_t bank_prev(bank_t b);
    bank_prev = (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

  function automatic bank_t bank_next(bank_t b);
    bank_next = (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  logic [COL_BITS-1:0]     w_last_q, w_last_d;
  logic [PAIR_AW-1:0]      hw_last_q, hw_last_d;
  logic [ROW_BITS-1:0]     h_last_q, h_last_d;
  logic                    h_odd_q, h_odd_d;
  logic                    h_two_q, h_two_d;
  logic [OUT_ROW_BITS-1:0] drow_q, drow_d;

  logic signed [SAMPLE_BITS-1:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [BLUR_BITS-1:0]   prb_q, prb_d;
  logic [COL_BITS-1:0]           col_q, col_d;
  logic [ROW_BITS-1:0]           row_q, row_d;
  bank_t                         rmod_q, rmod_d;
  logic                          pend_q, pend_d;
  logic [PAIR_AW-1:0]            dcol_q, dcol_d;
  bank_t                         dline_q, dline_d;

  logic [WCFG_BITS-1:0]        w_raw, w_eff;
  logic [HCFG_BITS-1:0]        h_raw, h_eff;
  logic signed [BLUR_BITS-1:0] rb, rb2;
  pair_t                       pair_mid, pair_end, pair;
  logic                        is_drain, pix, col_last, emit_end, emit_mid, pix_emit;
  logic                        row_even_ge2;
  pair_addr_t                  pidx;

  always_comb begin
    w_raw = cfg_data_i[WCFG_BITS-1:0];
    h_raw = cfg_data_i[HCFG_BITS-1:0];
    if (w_raw < W_MIN) begin
      w_eff = W_MIN;
    end else if (w_raw > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < H_MIN) begin
      h_eff = H_MIN;
    end else if (h_raw > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = h_raw;
    end
  end

  always_comb begin
    w_last_d  = w_last_q;
    hw_last_d = hw_last_q;
    h_last_d  = h_last_q;
    h_odd_d   = h_odd_q;
    h_two_d   = h_two_q;
    drow_d    = drow_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          w_last_d  = COL_BITS'(w_eff - WCFG_BITS'(1));
          hw_last_d = PAIR_AW'(w_eff[WCFG_BITS-1:1] - (WCFG_BITS-1)'(1));
        end
        REG_FRAME_HEIGHT: begin
          h_last_d = ROW_BITS'(h_eff - HCFG_BITS'(1));
          h_odd_d  = h_eff[0];
          h_two_d  = (h_eff == H_MIN);
          drow_d   = OUT_ROW_BITS'(h_eff[HCFG_BITS-1:1] - (HCFG_BITS-1)'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rb       = BLUR_BITS'(p2_q) + (BLUR_BITS'(p1_q) <<< 1) + BLUR_BITS'(item_i.sample);
    rb2      = BLUR_BITS'(p1_q) + (BLUR_BITS'(item_i.sample) <<< 1)
             + BLUR_BITS'(item_i.sample);
    pair_mid = PAIR_BITS'(prb_q) + PAIR_BITS'(rb);
    pair_end = PAIR_BITS'(rb) + PAIR_BITS'(rb2);

    is_drain     = (item_i.operation == OP_DRAIN);
    pix          = !is_drain && !pend_q;
    col_last     = (col_q == w_last_q);
    emit_end     = col_last && col_q[0];
    emit_mid     = !col_q[0] && (col_q != '0);
    pix_emit     = pix && (emit_end || emit_mid);
    pair         = emit_end ? pair_end : pair_mid;
    pidx         = emit_end ? col_q[COL_BITS-1:1] : col_q[COL_BITS-1:1] - 1'b1;
    row_even_ge2 = !row_q[0] && (row_q != '0);

    rd_addr_o = is_drain ? dcol_q : pidx;

    wr_o.we   = accept_i && pix_emit;
    wr_o.bank = rmod_q;
    wr_o.addr = pidx;
    wr_o.data = pair;

    if (is_drain) begin
      req_o.emit  = pend_q;
      req_o.drain = 1'b1;
      req_o.b1    = dline_q;
      req_o.b2    = bank_prev(dline_q);
      req_o.b3    = bank_next(dline_q);
      req_o.dup   = h_two_q;
      req_o.cur   = '0;
      req_o.col   = dcol_q;
      req_o.row   = drow_q;
      req_o.last  = (dcol_q == hw_last_q);
    end else begin
      req_o.emit  = pix_emit && row_even_ge2;
      req_o.drain = 1'b0;
      req_o.b1    = bank_prev(rmod_q);
      req_o.b2    = bank_next(rmod_q);
      req_o.b3    = rmod_q;
      req_o.dup   = (row_q == ROW_BITS'(2));
      req_o.cur   = pair;
      req_o.col   = pidx;
      req_o.row   = OUT_ROW_BITS'(row_q[ROW_BITS-1:1] - 1'b1);
      req_o.last  = h_odd_q && (row_q == h_last_q) && (pidx == hw_last_q);
    end
  end

  always_comb begin
    p1_d    = p1_q;
    p2_d    = p2_q;
    prb_d   = prb_q;
    col_d   = col_q;
    row_d   = row_q;
    rmod_d  = rmod_q;
    pend_d  = pend_q;
    dcol_d  = dcol_q;
    dline_d = dline_q;
    if (cfg_we_i) begin
      p1_d   = '0;
      p2_d   = '0;
      prb_d  = '0;
      col_d  = '0;
      row_d  = '0;
      rmod_d = '0;
      pend_d = 1'b0;
      dcol_d = '0;
    end else if (accept_i && is_drain) begin
      if (pend_q) begin
        if (dcol_q == hw_last_q) begin
          pend_d = 1'b0;
          dcol_d = '0;
        end else begin
          dcol_d = dcol_q + 1'b1;
        end
      end
    end else if (accept_i && pix) begin
      if (col_q == '0) begin
        p1_d = item_i.sample;
        p2_d = item_i.sample;
      end else begin
        p1_d = item_i.sample;
        p2_d = p1_q;
      end
      if (col_q[0]) begin
        prb_d = rb;
      end
      if (col_last) begin
        col_d = '0;
        if (row_q == h_last_q) begin
          row_d  = '0;
          rmod_d = '0;
          if (!h_odd_q) begin
            pend_d  = 1'b1;
            dcol_d  = '0;
            dline_d = rmod_q;
          end
        end else begin
          row_d  = row_q + 1'b1;
          rmod_d = bank_next(rmod_q);
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q  <= COL_BITS'(RESET_WIDTH - 1);
      hw_last_q <= PAIR_AW'(RESET_WIDTH / 2 - 1);
      h_last_q  <= ROW_BITS'(RESET_HEIGHT - 1);
      h_odd_q   <= 1'(RESET_HEIGHT % 2);
      h_two_q   <= (RESET_HEIGHT == 2);
      drow_q    <= OUT_ROW_BITS'(RESET_HEIGHT / 2 - 1);
      p1_q      <= '0;
      p2_q      <= '0;
      prb_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      rmod_q    <= '0;
      pend_q    <= 1'b0;
      dcol_q    <= '0;
      dline_q   <= '0;
    end else begin
      w_last_q  <= w_last_d;
      hw_last_q <= hw_last_d;
      h_last_q  <= h_last_d;
      h_odd_q   <= h_odd_d;
      h_two_q   <= h_two_d;
      drow_q    <= drow_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      prb_q     <= prb_d;
      col_q     <= col_d;
      row_q     <= row_d;
      rmod_q    <= rmod_d;
      pend_q    <= pend_d;
      dcol_q    <= dcol_d;
      dline_q   <= dline_d;
    end
  end

endmodule

// File: rtl/core/gpr_back.sv
// Back end: column blur sums, 2x2 average, rounding and output register.
`timescale 1ns / 1ps
module gpr_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  gpr_pkg::gpr_req_t                      req_i,
  input  gpr_pkg::pair_t [gpr_pkg::NUM_BANKS-1:0] rd_data_i,
  input  logic                                   out_ready_i,
  output logic                                   adv_o,
  output logic                                   out_valid_o,
  output gpr_pkg::gpr_out_t                      out_data_o
);
  import gpr_pkg::*;

  typedef struct packed {
    logic [OUT_COL_BITS-1:0] col;
    logic [OUT_ROW_BITS-1:0] row;
    logic                    last;
  } pos_t;

  function automatic pair_t pick(pair_t [NUM_BANKS-1:0] d, bank_t b);
    case (b)
      2'd0:    pick = d[0];
      2'd1:    pick = d[1];
      default: pick = d[2];
    endcase
  endfunction

  logic     s1_v_q, s2_v_q, s3_v_q, out_v_q;
  gpr_req_t s1_q;
  logic signed [HALF_BITS-1:0] u_q, v_q;
  pos_t     s2_pos_q, s3_pos_q;
  logic signed [SUM_BITS-1:0] tot_q, rnd;
  gpr_out_t out_q;

  pair_t a1, a2, a3, x;
  logic  o_en, en3, en2, en1;

  assign o_en  = !out_v_q || out_ready_i;
  assign en3   = !s3_v_q || o_en;
  assign en2   = !s2_v_q || en3;
  assign en1   = !s1_v_q || en2;
  assign adv_o = en1;

  always_comb begin
    a1  = pick(rd_data_i, s1_q.b1);
    a2  = pick(rd_data_i, s1_q.b2);
    a3  = s1_q.dup ? a2 : pick(rd_data_i, s1_q.b3);
    x   = s1_q.drain ? a1 : s1_q.cur;
    rnd = tot_q + SUM_BITS'(32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= accept_i && req_i.emit;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (o_en) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= req_i;
    end
    if (en2) begin
      u_q      <= HALF_BITS'(a1) + HALF_BITS'(a2);
      v_q      <= HALF_BITS'(a3) + HALF_BITS'(x);
      s2_pos_q <= '{col: s1_q.col, row: s1_q.row, last: s1_q.last};
    end
    if (en3) begin
      tot_q    <= SUM_BITS'(v_q) + SUM_BITS'(u_q) + (SUM_BITS'(u_q) <<< 1);
      s3_pos_q <= s2_pos_q;
    end
    if (o_en) begin
      out_q.reduced_sample <= rnd[SUM_BITS-1:6];
      out_q.out_col        <= s3_pos_q.col;
      out_q.out_row        <= s3_pos_q.row;
      out_q.last_of_frame  <= s3_pos_q.last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/gaussian_pyramid_reduce.sv
// Top level of the one-level Gaussian pyramid reduce (1-2-1 blur, 2x2 average).
// Throughput: one item per clock unless back-pressure stalls; each of the three
// line store banks takes one read per advancing cycle; at most one is written.
// A result passes s1, s2 and s3, then stays in the output register until taken.
// Reset clears counters, pixel registers, drain state and configuration to
// 2048 x 2048; the line stores are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gaussian_pyramid_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [gpr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gpr_pkg::gpr_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output gpr_pkg::gpr_out_t                 out_data_o
);
  import gpr_pkg::*;

  logic                    accept, adv;
  gpr_req_t                req;
  gpr_wr_t                 wr;
  pair_addr_t              rd_addr;
  pair_t [NUM_BANKS-1:0]   rd_data;
  logic [NUM_BANKS-1:0]    bank_we;

  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  gpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .req_o      (req),
    .wr_o       (wr),
    .rd_addr_o  (rd_addr)
  );

  for (genvar i = 0; i < NUM_BANKS; i++) begin : g_bank
    assign bank_we[i] = wr.we && (wr.bank == bank_t'(i));

    gpr_line_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[i]),
      .waddr_i (wr.addr),
      .wdata_i (wr.data),
      .re_i    (adv),
      .raddr_i (rd_addr),
      .rdata_o (rd_data[i])
    );
  end

  gpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req),
    .rd_data_i   (rd_data),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `GPR_ASSERT_IMP(a_wr_on_pixel, wr.we, in_valid_i && in_ready_o && !in_data_i.operation, "line store write without a pixel transfer")
  `GPR_ASSERT_ALWAYS(a_one_bank_wr, $onehot0(bank_we), "more than one line store bank written")
  `GPR_ASSERT_ALWAYS(a_banks_apart, (req.b1 != req.b2) && (req.b1 != req.b3) && (req.b2 != req.b3) && (req.b1 != 2'd3) && (req.b2 != 2'd3) && (req.b3 != 2'd3), "line store banks overlap")

endmodule
